// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hw/rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and types of the TF-IDF document norm accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package tfn_pkg;

   localparam int MAX_DOCS    = 65536;
   localparam int NUM_INDEXES = 2;
   localparam int FRAC_BITS   = 16;

   localparam int MEM_DEPTH = MAX_DOCS * NUM_INDEXES;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   localparam int DOC_W   = 16;
   localparam int TF_W    = 16;
   localparam int DF_W    = 24;
   localparam int TOTAL_W = 24;
   localparam int LEN_W   = 40;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   localparam int SUM_W = 32 + FRAC_BITS;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // idf divider and log unit
   localparam int DIV_W     = TOTAL_W + FRAC_BITS;
   localparam int LOG_INT_W = $clog2(DIV_W - FRAC_BITS);
   localparam int LOG_W     = LOG_INT_W + FRAC_BITS;
   localparam int L10_W     = LOG_W - 1;
   localparam int LL_W      = 2 * L10_W;
   localparam int W_W       = LL_W - FRAC_BITS + 1;
   localparam int ADD_W     = 2 * W_W - FRAC_BITS;
   localparam logic [30:0] LOG10_OF_2_Q32 = 31'd1292913987;

   // square root unit
   localparam int SQRT_STEPS = 16 + FRAC_BITS;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 2;
   localparam int RAD_W      = 2 * SQRT_STEPS;

   localparam int CNT_W = 6;

   localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SAT     = 2'd2;

   // work classes decided by the front end
   localparam logic [1:0] KIND_DONE  = 2'd0;
   localparam logic [1:0] KIND_ACC   = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]         kind;
      logic [STAT_W-1:0]  status;
      logic [ADDR_W-1:0]  addr;
      logic [DOC_W-1:0]   doc;
      logic [TF_W-1:0]    tf;
      logic [DF_W-1:0]    df;
      logic [TOTAL_W-1:0] total;
   } entry_type;

endpackage
`default_nettype wire

// File: hw/rtl/tfidf_document_norm_accumulator.sv
// Work per item: invalid or unused go straight to the output, clear zeroes one
//   sum word, read runs a 32-step root, accumulate a 40-step idf divide, two log
//   passes of up to 23 normalize shifts plus 16 squarings each, multiply, add.
// Throughput: one item at a time in the back-end sequencer; a 2-item queue
//   lets input be taken while an item is worked on or a result waits.
// Reset: synchronous, active high; the whole sum memory is then cleared, no input.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tfidf_document_norm_accumulator
// Per-document TF-IDF weight-square sums with vector length readout.
// ----------------------------------------------------------------------------
`default_nettype none
module tfidf_document_norm_accumulator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // items in
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [55:0]                 req_tdata,  // doc_id[15:0], term_freq[31:16],
                                                        // doc_freq[55:32]
   input  wire logic [2:0]                  req_tuser,  // command[1:0], index_select[2]
   // results out
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [55:0]                      rsp_tdata,  // doc_id_out[15:0],
                                                        // doc_length[55:16]
   output logic [1:0]                       rsp_tuser,  // status[1:0]
   // register writes: 0 total_docs_main, 1 total_docs_anchor
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [23:0]                 csr_data
);

   // front end -> queue -> back end
   tfn_pkg::entry_type q_entry, q_head;
   logic q_push, q_pop, q_full, q_not_empty;
   logic init_busy;

   tfn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .init_busy  (init_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   tfn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // back end owns the sum memory and the output register
   tfn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .init_busy   (init_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // no item taken while the memory clear runs
   `ASSERT_NEVER(a_no_accept_in_init, clock, reset, init_busy && req_tready)
   // queue never written when full
   `ASSERT_NEVER(a_queue_overrun, clock, reset, q_push && q_full)
   // only a good read carries a length
   `ASSERT_HOLDS(a_bad_len_zero, clock, reset, rsp_tvalid && rsp_tuser != tfn_pkg::STATUS_OK |-> rsp_tdata[55:16] == '0)

endmodule
`default_nettype wire

// File: hw/rtl/tfn_queue.sv
// ----------------------------------------------------------------------------
// tfn_queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  tfn_pkg::entry_type      push_entry,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output tfn_pkg::entry_type      head
);

   tfn_pkg::entry_type slot_ff [tfn_pkg::QUEUE_DEPTH];
   logic [tfn_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tfn_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tfn_pkg::QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (tfn_pkg::QPTR_W+1)'(tfn_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tfn_pkg::QPTR_W'(tfn_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tfn_pkg::QPTR_W'(tfn_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front
// Accepts items, holds the document totals and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [55:0]                 req_tdata,  // doc_id, term_freq, doc_freq
   input  wire logic [2:0]                  req_tuser,  // command, index_select
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [tfn_pkg::TOTAL_W-1:0] csr_data,
   input  wire logic                        init_busy,
   input  wire logic                        q_full,
   output logic                             q_push,
   output tfn_pkg::entry_type               q_entry
);

   localparam logic CSR_TOTAL_MAIN   = 1'b0;
   localparam logic CSR_TOTAL_ANCHOR = 1'b1;

   logic [tfn_pkg::TOTAL_W-1:0] total_main_ff, total_anchor_ff;
   logic [tfn_pkg::CMD_W-1:0]   cmd;
   logic                        sel;
   logic                        bad_addr;
   logic [tfn_pkg::TOTAL_W-1:0] total;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full && !init_busy;
   assign q_push     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_main_ff   <= tfn_pkg::TOTAL_W'(1);
         total_anchor_ff <= tfn_pkg::TOTAL_W'(1);
      end else if (csr_valid) begin
         if (csr_index == CSR_TOTAL_MAIN) begin
            total_main_ff <= csr_data;
         end
         if (csr_index == CSR_TOTAL_ANCHOR) begin
            total_anchor_ff <= csr_data;
         end
      end
   end

   assign cmd   = req_tuser[1:0];
   assign sel   = req_tuser[2];
   assign total = sel ? total_anchor_ff : total_main_ff;
   assign bad_addr = (32'(req_tdata[15:0]) >= tfn_pkg::MAX_DOCS) ||
                     (32'(sel) >= tfn_pkg::NUM_INDEXES);

   always_comb begin
      q_entry.doc    = req_tdata[15:0];
      q_entry.tf     = req_tdata[31:16];
      q_entry.df     = req_tdata[55:32];
      q_entry.total  = total;
      q_entry.addr   = tfn_pkg::ADDR_W'(32'(sel) * tfn_pkg::MAX_DOCS +
                                        32'(req_tdata[15:0]));
      q_entry.kind   = tfn_pkg::KIND_DONE;
      q_entry.status = tfn_pkg::STATUS_OK;
      if (bad_addr) begin
         q_entry.status = (cmd == tfn_pkg::CMD_NOP) ? tfn_pkg::STATUS_OK
                                                    : tfn_pkg::STATUS_INVALID;
      end else begin
         case (cmd)
            tfn_pkg::CMD_ACC: begin
               if (q_entry.tf == '0 || q_entry.df == '0 || q_entry.df > total) begin
                  q_entry.status = tfn_pkg::STATUS_INVALID;
               end else begin
                  q_entry.kind = tfn_pkg::KIND_ACC;
               end
            end
            tfn_pkg::CMD_READ:  q_entry.kind = tfn_pkg::KIND_READ;
            tfn_pkg::CMD_CLEAR: q_entry.kind = tfn_pkg::KIND_CLEAR;
            default:            q_entry.kind = tfn_pkg::KIND_DONE;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/tfn_back.sv
// ----------------------------------------------------------------------------
// tfn_back
// Sequencer: idf divide, log unit, weight square, sum memory, square root.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_not_empty,
   input  tfn_pkg::entry_type               q_head,
   output logic                             q_pop,
   output logic                             init_busy,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [55:0]                      rsp_tdata,  // doc_id_out, doc_length
   output logic [tfn_pkg::STAT_W-1:0]       rsp_tuser   // status
);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_SQR   = 4'd4;
   localparam logic [3:0] S_L10   = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_WSQ   = 4'd7;
   localparam logic [3:0] S_ADD   = 4'd8;
   localparam logic [3:0] S_RDW   = 4'd9;
   localparam logic [3:0] S_SQLD  = 4'd10;
   localparam logic [3:0] S_SQRT  = 4'd11;
   localparam logic [3:0] S_CLR   = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   localparam int DW = tfn_pkg::DIV_W;
   localparam int FB = tfn_pkg::FRAC_BITS;

   logic [3:0] state_ff, state_in;
   logic [tfn_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [tfn_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       pass_ff, pass_in;

   // item payload
   logic [tfn_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [tfn_pkg::DOC_W-1:0]   doc_ff, doc_in;
   logic [tfn_pkg::TF_W-1:0]    tf_ff, tf_in;
   logic [tfn_pkg::DF_W-1:0]    df_ff, df_in;
   logic [tfn_pkg::STAT_W-1:0]  status_ff, status_in;
   logic [tfn_pkg::LEN_W-1:0]   len_ff, len_in;

   // arithmetic
   logic [DW-1:0]                x_ff, x_in;
   logic [tfn_pkg::DF_W-1:0]     rem_ff, rem_in;
   logic [tfn_pkg::CNT_W-1:0]    p_ff, p_in;
   logic [31:0]                  y_ff, y_in;
   logic [FB-1:0]                frac_ff, frac_in;
   logic [tfn_pkg::L10_W-1:0]    lidf_ff, lidf_in, ltf_ff, ltf_in;
   logic [tfn_pkg::LL_W-1:0]     ll_ff, ll_in;
   logic [tfn_pkg::ADD_W-1:0]    add_ff, add_in;
   logic [tfn_pkg::RAD_W-1:0]    v_ff, v_in;
   logic [tfn_pkg::REM_W-1:0]    srem_ff, srem_in;
   logic [tfn_pkg::ROOT_W-1:0]   root_ff, root_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [55:0]                  rsp_data_ff, rsp_data_in;
   logic [tfn_pkg::STAT_W-1:0]   rsp_user_ff, rsp_user_in;

   // sum memory
   logic [tfn_pkg::SUM_W-1:0] mem [tfn_pkg::MEM_DEPTH];
   logic [tfn_pkg::SUM_W-1:0] mem_q_ff;
   logic                      wr_en;
   logic [tfn_pkg::ADDR_W-1:0] wr_addr;
   logic [tfn_pkg::SUM_W-1:0]  wr_data;

   // step temporaries
   logic [tfn_pkg::DF_W:0]       div_t;
   logic                         div_bit;
   logic [63:0]                  sq;
   logic [32:0]                  sq_sh;
   logic [tfn_pkg::LOG_W-1:0]    lg;
   logic [tfn_pkg::LOG_W+30:0]   l10_prod;
   logic [tfn_pkg::W_W-1:0]      w;
   logic [2*tfn_pkg::W_W-1:0]    wsq;
   logic [tfn_pkg::SUM_W:0]      new_sum;
   logic [tfn_pkg::REM_W+1:0]    s_t, s_trial;

   assign init_busy  = (state_ff == S_INIT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign q_pop      = (state_ff == S_IDLE) && q_not_empty;

   always_comb begin
      div_t    = {rem_ff, x_ff[DW-1]};
      div_bit  = (div_t >= {1'b0, df_ff});
      sq       = 64'(y_ff) * 64'(y_ff);
      sq_sh    = sq[63:31];
      lg       = {tfn_pkg::LOG_INT_W'(p_ff - tfn_pkg::CNT_W'(FB)), frac_ff};
      l10_prod = (tfn_pkg::LOG_W+31)'(lg) * (tfn_pkg::LOG_W+31)'(tfn_pkg::LOG10_OF_2_Q32);
      w        = tfn_pkg::W_W'(1 << FB) + tfn_pkg::W_W'(ll_ff[tfn_pkg::LL_W-1:FB]);
      wsq      = (2*tfn_pkg::W_W)'(w) * (2*tfn_pkg::W_W)'(w);
      new_sum  = (tfn_pkg::SUM_W+1)'(mem_q_ff) + (tfn_pkg::SUM_W+1)'(add_ff);
      s_t      = {srem_ff, v_ff[tfn_pkg::RAD_W-1 -: 2]};
      s_trial  = (tfn_pkg::REM_W+2)'({root_ff, 2'b01});
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cnt_in      = cnt_ff;
      pass_in     = pass_ff;
      addr_in     = addr_ff;
      doc_in      = doc_ff;
      tf_in       = tf_ff;
      df_in       = df_ff;
      status_in   = status_ff;
      len_in      = len_ff;
      x_in        = x_ff;
      rem_in      = rem_ff;
      p_in        = p_ff;
      y_in        = y_ff;
      frac_in     = frac_ff;
      lidf_in     = lidf_ff;
      ltf_in      = ltf_ff;
      ll_in       = ll_ff;
      add_in      = add_ff;
      v_in        = v_ff;
      srem_in     = srem_ff;
      root_in     = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = '0;

      case (state_ff)
         S_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == tfn_pkg::ADDR_W'(tfn_pkg::MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_not_empty) begin
               addr_in   = q_head.addr;
               doc_in    = q_head.doc;
               tf_in     = q_head.tf;
               df_in     = q_head.df;
               status_in = q_head.status;
               len_in    = '0;
               x_in      = {q_head.total, FB'(0)};
               rem_in    = '0;
               cnt_in    = '0;
               pass_in   = 1'b0;
               case (q_head.kind)
                  tfn_pkg::KIND_ACC:   state_in = S_DIV;
                  tfn_pkg::KIND_READ:  state_in = S_RDW;
                  tfn_pkg::KIND_CLEAR: state_in = S_CLR;
                  default:             state_in = S_OUT;
               endcase
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = div_bit ? tfn_pkg::DF_W'(div_t - {1'b0, df_ff})
                             : tfn_pkg::DF_W'(div_t);
            x_in   = {x_ff[DW-2:0], div_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tfn_pkg::CNT_W'(DW - 1)) begin
               p_in     = tfn_pkg::CNT_W'(DW - 1);
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (x_ff[DW-1]) begin
               y_in     = x_ff[DW-1 -: 32];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = S_SQR;
            end else begin
               x_in = {x_ff[DW-2:0], 1'b0};
               p_in = p_ff - 1'b1;
            end
         end
         S_SQR: begin
            if (sq_sh[32]) begin
               frac_in = {frac_ff[FB-2:0], 1'b1};
               y_in    = sq_sh[32:1];
            end else begin
               frac_in = {frac_ff[FB-2:0], 1'b0};
               y_in    = sq_sh[31:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tfn_pkg::CNT_W'(FB - 1)) begin
               state_in = S_L10;
            end
         end
         S_L10: begin
            if (!pass_ff) begin
               lidf_in  = l10_prod[tfn_pkg::LOG_W+30:32];
               x_in     = {DW'(tf_ff)} << FB;
               p_in     = tfn_pkg::CNT_W'(DW - 1);
               pass_in  = 1'b1;
               state_in = S_NORM;
            end else begin
               ltf_in   = l10_prod[tfn_pkg::LOG_W+30:32];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            ll_in    = tfn_pkg::LL_W'(ltf_ff) * tfn_pkg::LL_W'(lidf_ff);
            state_in = S_WSQ;
         end
         S_WSQ: begin
            add_in   = wsq[2*tfn_pkg::W_W-1:FB];
            state_in = S_ADD;
         end
         S_ADD: begin
            wr_en = 1'b1;
            if (new_sum > (tfn_pkg::SUM_W+1)'(tfn_pkg::SUM_MAX)) begin
               wr_data   = tfn_pkg::SUM_MAX;
               status_in = tfn_pkg::STATUS_SAT;
            end else begin
               wr_data = new_sum[tfn_pkg::SUM_W-1:0];
            end
            state_in = S_OUT;
         end
         S_RDW: begin
            state_in = S_SQLD;
         end
         S_SQLD: begin
            v_in     = {mem_q_ff, FB'(0)};
            srem_in  = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // one root digit per cycle
            if (s_t >= s_trial) begin
               srem_in = tfn_pkg::REM_W'(s_t - s_trial);
               root_in = {root_ff[tfn_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = tfn_pkg::REM_W'(s_t);
               root_in = {root_ff[tfn_pkg::ROOT_W-2:0], 1'b0};
            end
            v_in   = {v_ff[tfn_pkg::RAD_W-3:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tfn_pkg::CNT_W'(tfn_pkg::SQRT_STEPS - 1)) begin
               len_in   = tfn_pkg::LEN_W'(root_in);
               state_in = S_OUT;
            end
         end
         S_CLR: begin
            wr_en    = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {len_ff, doc_ff};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pass_ff     <= pass_in;
      addr_ff     <= addr_in;
      doc_ff      <= doc_in;
      tf_ff       <= tf_in;
      df_ff       <= df_in;
      status_ff   <= status_in;
      len_ff      <= len_in;
      x_ff        <= x_in;
      rem_ff      <= rem_in;
      p_ff        <= p_in;
      y_ff        <= y_in;
      frac_ff     <= frac_in;
      lidf_ff     <= lidf_in;
      ltf_ff      <= ltf_in;
      ll_ff       <= ll_in;
      add_ff      <= add_in;
      v_ff        <= v_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[addr_ff];
   end

endmodule
`default_nettype wire
